// ===== sv/tlik_pkg.sv =====
// Shared types, constants and the arctangent step table of the two-link arm IK block.
`default_nettype none

package tlik_pkg;

  localparam int ANGLE_FRAC_BITS = 8;
  localparam int CORDIC_STAGES   = 16;
  localparam int SERVO_MAX       = 2047;

  localparam int XY_W     = 9;
  localparam int LEN_W    = 7;
  localparam int TICK_W   = 13;
  localparam int POS_W    = 11;
  localparam int R2_W     = 17;
  localparam int LIM_W    = 16;
  localparam int RAD_W    = 34;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 2;
  localparam int OP_W     = ROOT_W + 1;
  localparam int CW       = 42;
  localparam int ZW       = 36;
  localparam int OPERAND_SHIFT = 20;
  localparam int AW       = ANGLE_FRAC_BITS + 12;
  localparam int DEG_SH   = 56 - ANGLE_FRAC_BITS;
  localparam int MAG_W    = ZW - 1;
  localparam int MLO_W    = 18;
  localparam int MHI_W    = MAG_W - MLO_W;
  localparam int CONST_W  = 30;
  localparam int PROD_W   = MAG_W + CONST_W;
  localparam int TP_W     = AW - 1 + TICK_W;
  localparam int POS_SH   = ANGLE_FRAC_BITS + 8;
  localparam int PQ_W     = TP_W - POS_SH;
  localparam int CFG_IDX_W = 1;

  localparam longint PI_4_Q32 = 64'sd3373259426;
  localparam longint PI_2_Q32 = 64'sd6746518852;
  localparam logic [CONST_W-1:0] DEG_PER_RAD_Q24 = 30'd961263669;

  // atan(2^-i) in radians, Q32, rounded from the power series; covers up to 24 stages.
  localparam longint ATAN_STEP_Q32 [24] = '{
    PI_4_Q32,        64'sd1991351318, 64'sd1052175346, 64'sd534100635,
    64'sd268086748,  64'sd134174063,  64'sd67103403,   64'sd33553749,
    64'sd16777131,   64'sd8388597,    64'sd4194303,    64'sd2097152,
    64'sd1048576,    64'sd524288,     64'sd262144,     64'sd131072,
    64'sd65536,      64'sd32768,      64'sd16384,      64'sd8192,
    64'sd4096,       64'sd2048,       64'sd1024,       64'sd512
  };

  typedef logic signed [XY_W-1:0] coord_t;
  typedef logic signed [OP_W-1:0] op_t;
  typedef logic signed [CW-1:0]   vec_t;
  typedef logic signed [ZW-1:0]   ang_t;
  typedef logic signed [AW-1:0]   deg_t;

  localparam deg_t DEG90  = deg_t'(90 * (2 ** ANGLE_FRAC_BITS));
  localparam deg_t DEG180 = deg_t'(180 * (2 ** ANGLE_FRAC_BITS));
  localparam deg_t DEG270 = deg_t'(270 * (2 ** ANGLE_FRAC_BITS));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEG_LEN = 1'b0,
    REG_TICKS   = 1'b1
  } cfg_reg_e;

  // Data that rides alongside the arithmetic.
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   origin;
    logic   beyond;
  } side_t;

endpackage

`default_nettype wire

// ===== sv/tlik_sqrt.sv =====
// Dual pipelined integer square root, one result bit per stage.
`default_nettype none

module tlik_sqrt (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [tlik_pkg::RAD_W-1:0]   rad_i [2],
  input  wire tlik_pkg::side_t              side_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [tlik_pkg::ROOT_W-1:0]       root_o [2],
  output tlik_pkg::side_t                   side_o
);
  import tlik_pkg::*;

  localparam int N = ROOT_W;

  logic [N-1:0]       v_q;
  logic [N:0]         ld;
  logic [REM_W-1:0]   rem_q  [N][2];
  logic [ROOT_W-1:0]  root_q [N][2];
  logic [RAD_W-1:0]   rad_q  [N][2];
  side_t              side_q [N];

  assign ld[N]      = out_ready_i;
  assign in_ready_o = ld[0];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [REM_W-1:0]  rem_p  [2];
    logic [ROOT_W-1:0] root_p [2];
    logic [RAD_W-1:0]  rad_p  [2];
    side_t             side_p;
    logic              v_p;

    assign ld[k] = !v_q[k] || ld[k+1];

    if (k == 0) begin : g_first
      assign rem_p  = '{default: '0};
      assign root_p = '{default: '0};
      assign rad_p  = rad_i;
      assign side_p = side_i;
      assign v_p    = in_valid_i;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign rad_p  = rad_q[k-1];
      assign side_p = side_q[k-1];
      assign v_p    = v_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (ld[k]) begin
        v_q[k] <= v_p;
      end
    end

    for (genvar j = 0; j < 2; j++) begin : g_lane
      logic [REM_W+1:0] rem4;
      logic [REM_W+1:0] trial;
      logic             ge;

      assign rem4  = {rem_p[j], rad_p[j][RAD_W-1 -: 2]};
      assign trial = (REM_W+2)'({root_p[j], 2'b01});
      assign ge    = rem4 >= trial;

      always_ff @(posedge clk_i) begin
        if (ld[k]) begin
          rem_q[k][j]  <= ge ? REM_W'(rem4 - trial) : REM_W'(rem4);
          root_q[k][j] <= {root_p[j][ROOT_W-2:0], ge};
          rad_q[k][j]  <= rad_p[j] << 2;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (ld[k]) begin
        side_q[k] <= side_p;
      end
    end
  end

  assign out_valid_o = v_q[N-1];
  assign root_o      = root_q[N-1];
  assign side_o      = side_q[N-1];

endmodule

`default_nettype wire

// ===== sv/tlik_cordic.sv =====
// Dual pipelined vectoring CORDIC giving atan2 in Q32 radians.
`default_nettype none

module tlik_cordic (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire tlik_pkg::op_t     in_x_i [2],
  input  wire tlik_pkg::op_t     in_y_i [2],
  input  wire tlik_pkg::side_t   side_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output tlik_pkg::ang_t         z_o [2],
  output tlik_pkg::side_t        side_o
);
  import tlik_pkg::*;

  localparam int N = CORDIC_STAGES + 1;

  logic [N-1:0] v_q;
  logic [N:0]   ld;
  vec_t         vx_q [N][2];
  vec_t         vy_q [N][2];
  ang_t         z_q  [N][2];
  logic         zero_q [N][2];
  side_t        side_q [N];

  assign ld[N]      = out_ready_i;
  assign in_ready_o = ld[0];

  for (genvar k = 0; k < N; k++) begin : g_stage
    assign ld[k] = !v_q[k] || ld[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (ld[k]) begin
        v_q[k] <= (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k-1];
      end
    end

    if (k == 0) begin : g_pre
      // Quadrant fold: x < 0 is turned by +-90 degrees first.
      for (genvar j = 0; j < 2; j++) begin : g_lane
        op_t  ax, ay;
        ang_t az;
        vec_t ex, ey;

        always_comb begin
          ax = in_x_i[j];
          ay = in_y_i[j];
          az = '0;
          if (in_x_i[j] < 0) begin
            if (in_y_i[j] >= 0) begin
              ax = in_y_i[j];
              ay = -in_x_i[j];
              az = ang_t'(PI_2_Q32);
            end else begin
              ax = -in_y_i[j];
              ay = in_x_i[j];
              az = -ang_t'(PI_2_Q32);
            end
          end
        end

        assign ex = {{(CW-OP_W){ax[OP_W-1]}}, ax} <<< OPERAND_SHIFT;
        assign ey = {{(CW-OP_W){ay[OP_W-1]}}, ay} <<< OPERAND_SHIFT;

        always_ff @(posedge clk_i) begin
          if (ld[k]) begin
            vx_q[k][j]   <= ex;
            vy_q[k][j]   <= ey;
            z_q[k][j]    <= az;
            zero_q[k][j] <= (in_y_i[j] == '0) && !in_x_i[j][OP_W-1];
          end
        end
      end

      always_ff @(posedge clk_i) begin
        if (ld[k]) side_q[k] <= side_i;
      end
    end else begin : g_iter
      localparam ang_t StepAngle = ang_t'(ATAN_STEP_Q32[k - 1]);

      for (genvar j = 0; j < 2; j++) begin : g_lane
        vec_t dx, dy;
        logic up;

        assign dx = vy_q[k-1][j] >>> (k - 1);
        assign dy = vx_q[k-1][j] >>> (k - 1);
        assign up = vy_q[k-1][j] > 0;

        always_ff @(posedge clk_i) begin
          if (ld[k]) begin
            vx_q[k][j]   <= up ? vx_q[k-1][j] + dx : vx_q[k-1][j] - dx;
            vy_q[k][j]   <= up ? vy_q[k-1][j] - dy : vy_q[k-1][j] + dy;
            z_q[k][j]    <= up ? z_q[k-1][j] + StepAngle : z_q[k-1][j] - StepAngle;
            zero_q[k][j] <= zero_q[k-1][j];
          end
        end
      end

      always_ff @(posedge clk_i) begin
        if (ld[k]) side_q[k] <= side_q[k-1];
      end
    end
  end

  assign out_valid_o = v_q[N-1];
  assign side_o      = side_q[N-1];
  for (genvar j = 0; j < 2; j++) begin : g_out
    assign z_o[j] = zero_q[N-1][j] ? '0 : z_q[N-1][j];
  end

endmodule

`default_nettype wire

// ===== sv/two_link_arm_inverse_kinematics.sv =====
// Top level: two-link planar arm inverse kinematics, target point to servo positions.
//
// Usage
//   Slave stream carries one target per transfer (x, y in cm, signed).
//   Master stream returns one transfer per target: shoulder, elbow and wrist
//   servo positions, with tuser set when the point is out of reach or at the
//   origin. Order is kept; every target gives exactly one result.
//   Config port: cfg_we_i writes register cfg_idx_i (0: segment length cm,
//   1: ticks per degree, Q5.8). Write only while no transfer is in flight.
// Timing
//   40 register stages: one input stage, 17 square-root stages (one root bit
//   each), 17 CORDIC stages (fold plus 16 rotations), and five stages for
//   degree scaling, joint angle forms, servo scaling and saturation. A target
//   taken runs through them in order. Throughput: one target per cycle while
//   the sink is ready. Every stage has its own valid bit and loads whenever
//   it is empty or its successor loads, so a stalled sink fills the pipe
//   before tready drops and bubbles are squeezed out.
// Reset
//   All valid bits clear; registers return to L = 10 cm and 2911 ticks/deg.
`default_nettype none

module two_link_arm_inverse_kinematics (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [23:0]                   s_axis_tdata,  // target_x, target_y
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [39:0]                        m_axis_tdata,  // shoulder_pos, elbow_pos, wrist_pos
  output logic                               m_axis_tuser,  // out_of_reach
  input  wire logic                          cfg_we_i,
  input  wire logic [tlik_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [tlik_pkg::TICK_W-1:0]   cfg_data_i
);
  import tlik_pkg::*;

  // Config registers
  logic [LEN_W-1:0]  seg_len_q;
  logic [TICK_W-1:0] ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_len_q <= LEN_W'(10);
      ticks_q   <= TICK_W'(2911);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SEG_LEN: seg_len_q <= cfg_data_i[LEN_W-1:0];
        REG_TICKS:   ticks_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 0: squares, reach limit and the two radicands
  coord_t                in_x, in_y;
  logic signed [2*XY_W-1:0] xsq, ysq;
  logic [R2_W-1:0]       r2;
  logic [2*LEN_W-1:0]    lsq;
  logic [LIM_W-1:0]      lim;
  logic [R2_W-1:0]       slack;
  logic                  ld0;
  logic                  v0_q;
  logic [RAD_W-1:0]      rad_q [2];
  side_t                 side0_q;
  logic                  sq_ready;

  assign in_x  = s_axis_tdata[XY_W-1:0];
  assign in_y  = s_axis_tdata[2*XY_W-1:XY_W];
  assign xsq   = (2*XY_W)'(in_x) * (2*XY_W)'(in_x);
  assign ysq   = (2*XY_W)'(in_y) * (2*XY_W)'(in_y);
  assign r2    = R2_W'(xsq) + R2_W'(ysq);
  assign lsq   = (2*LEN_W)'(seg_len_q) * (2*LEN_W)'(seg_len_q);
  assign lim   = {lsq, 2'b00};      // 4 L^2
  assign slack = R2_W'(lim) - r2;   // meaningless when beyond reach, masked later

  assign ld0           = !v0_q || sq_ready;
  assign s_axis_tready = ld0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (ld0) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld0) begin
      rad_q[0]       <= RAD_W'({r2, 16'h0000});
      rad_q[1]       <= RAD_W'({slack[LIM_W-1:0], 16'h0000});
      side0_q.x      <= in_x;
      side0_q.y      <= in_y;
      side0_q.origin <= (in_x == '0) && (in_y == '0);
      side0_q.beyond <= r2 > R2_W'(lim);
    end
  end

  // Roots: u = sqrt(r^2), w = sqrt(4L^2 - r^2), both Q8
  logic              sq_valid;
  logic              cor_ready;
  logic [ROOT_W-1:0] root [2];
  side_t             side_sq;

  tlik_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v0_q),
    .in_ready_o  (sq_ready),
    .rad_i       (rad_q),
    .side_i      (side0_q),
    .out_valid_o (sq_valid),
    .out_ready_i (cor_ready),
    .root_o      (root),
    .side_o      (side_sq)
  );

  // Lane 0: atan2(y, x); lane 1: atan2(w, u) = half-fold angle
  op_t   cx [2];
  op_t   cy [2];
  logic  cor_valid;
  logic  ld1, ld2, ld3, ld4, ld5;
  ang_t  zq [2];
  side_t side_cor;

  assign cx[0] = {{(OP_W-XY_W){side_sq.x[XY_W-1]}}, side_sq.x};
  assign cy[0] = {{(OP_W-XY_W){side_sq.y[XY_W-1]}}, side_sq.y};
  assign cx[1] = {1'b0, root[0]};
  assign cy[1] = {1'b0, root[1]};

  tlik_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sq_valid),
    .in_ready_o  (cor_ready),
    .in_x_i      (cx),
    .in_y_i      (cy),
    .side_i      (side_sq),
    .out_valid_o (cor_valid),
    .out_ready_i (ld1),
    .z_o         (zq),
    .side_o      (side_cor)
  );

  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  assign ld5 = !v5_q || m_axis_tready;
  assign ld4 = !v4_q || ld5;
  assign ld3 = !v3_q || ld4;
  assign ld2 = !v2_q || ld3;
  assign ld1 = !v1_q || ld2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (ld1) v1_q <= cor_valid;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
      if (ld4) v4_q <= v3_q;
      if (ld5) v5_q <= v4_q;
    end
  end

  // Stage 1: |z| times 180/pi, split into two partial products
  logic [MLO_W+CONST_W-1:0] plo_q [2];
  logic [MHI_W+CONST_W-1:0] phi_q [2];
  logic                     neg1_q [2];
  logic                     origin1_q, beyond1_q;
  deg_t                     base2_q, a2_q;
  logic                     flag2_q;

  for (genvar j = 0; j < 2; j++) begin : g_deg
    ang_t             zabs;
    logic [MAG_W-1:0] mag;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] rnd;
    deg_t             dmag;

    assign zabs = zq[j][ZW-1] ? -zq[j] : zq[j];
    assign mag  = zabs[MAG_W-1:0];

    always_ff @(posedge clk_i) begin
      if (ld1) begin
        plo_q[j]  <= (MLO_W+CONST_W)'(mag[MLO_W-1:0]) *
                     (MLO_W+CONST_W)'(DEG_PER_RAD_Q24);
        phi_q[j]  <= (MHI_W+CONST_W)'(mag[MAG_W-1:MLO_W]) *
                     (MHI_W+CONST_W)'(DEG_PER_RAD_Q24);
        neg1_q[j] <= zq[j][ZW-1];
      end
    end

    // Stage 2 arithmetic: sum, round half away from zero, restore sign
    assign prod = (PROD_W'(phi_q[j]) << MLO_W) + PROD_W'(plo_q[j]);
    assign rnd  = prod + (PROD_W'(1) << (DEG_SH - 1));
    assign dmag = AW'(rnd >> DEG_SH);
    if (j == 0) begin : g_base
      always_ff @(posedge clk_i) begin
        if (ld2) base2_q <= neg1_q[j] ? -dmag : dmag;
      end
    end else begin : g_half
      always_ff @(posedge clk_i) begin
        if (ld2) begin
          if (origin1_q) a2_q <= DEG90;
          else if (beyond1_q) a2_q <= '0;
          else a2_q <= neg1_q[j] ? -dmag : dmag;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      origin1_q <= side_cor.origin;
      beyond1_q <= side_cor.beyond;
    end
    if (ld2) flag2_q <= origin1_q || beyond1_q;
  end

  // Stage 3: joint angles in degrees
  deg_t ang3_q [3];
  deg_t sh3, el3;
  logic flag3_q;

  assign sh3 = base2_q + a2_q;
  assign el3 = DEG180 - (a2_q <<< 1);

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      ang3_q[0] <= sh3;
      ang3_q[1] <= el3;
      ang3_q[2] <= DEG270 - sh3 - el3;
      flag3_q   <= flag2_q;
    end
  end

  // Stage 4: ticks product; stage 5: scale down and saturate
  logic [TP_W-1:0]  tp4_q [3];
  logic             pos4_q [3];
  logic             flag4_q;
  logic [POS_W-1:0] pos5_q [3];
  logic             flag5_q;

  for (genvar j = 0; j < 3; j++) begin : g_pos
    logic [PQ_W-1:0]  pq;
    logic [PQ_W-1:0]  sat;

    always_ff @(posedge clk_i) begin
      if (ld4) begin
        tp4_q[j]  <= TP_W'(ang3_q[j][AW-2:0]) * TP_W'(ticks_q);
        pos4_q[j] <= !ang3_q[j][AW-1] && (ang3_q[j] != '0);
      end
    end

    assign pq  = tp4_q[j][TP_W-1:POS_SH];
    assign sat = (pq > PQ_W'(SERVO_MAX)) ? PQ_W'(SERVO_MAX) : pq;

    always_ff @(posedge clk_i) begin
      if (ld5) pos5_q[j] <= pos4_q[j] ? sat[POS_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld4) flag4_q <= flag3_q;
    if (ld5) flag5_q <= flag4_q;
  end

  assign m_axis_tvalid = v5_q;
  assign m_axis_tdata  = {7'b0, pos5_q[2], pos5_q[1], pos5_q[0]};
  assign m_axis_tuser  = flag5_q;

`ifndef ASSERT_OFF
  // Input side only blocks when the first stage holds an item.
  a_ready_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> v0_q) else $error("input stalled with empty first stage");

  // A CORDIC result taken by stage 1 shows up there next cycle.
  a_cor_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_valid && ld1 |=> v1_q) else $error("CORDIC result lost at stage 1");

  // An item in stage 4 moves to the output register when it loads.
  a_out_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && ld5 |=> m_axis_tvalid) else $error("item lost before output");

  // A held output keeps its flag while the sink stalls.
  a_hold_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(flag5_q))
    else $error("flag changed during stall");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for the two-link arm inverse kinematics block: directed and random targets.
`timescale 1ns / 100ps
`default_nettype none

module testbench;
  import tlik_pkg::*;

  // One expected result transfer: the three servo positions and the flag.
  typedef struct {
    logic [POS_W-1:0] shoulder;
    logic [POS_W-1:0] elbow;
    logic [POS_W-1:0] wrist;
    logic             flag;
  } joint_pos_t;

  // Joint position predictor plus the queue of positions still owed by the block.
  class joint_scoreboard;
    int unsigned      seg_len;
    int unsigned      ticks;
    joint_pos_t       owed[$];
    int               errors;

    function new();
      seg_len = 10;
      ticks   = 2911;
      errors  = 0;
    endfunction

    // Register write as the block sees it; the segment length keeps 7 bits.
    function void set_reg(cfg_reg_e idx, int unsigned val);
      if (idx == REG_SEG_LEN) seg_len = val & 'h7F;
      else ticks = val & 'h1FFF;
    endfunction

    // atan(2^-i) in Q32 from its power series in Q60.
    function longint arctan_step(int i);
      longint unsigned acc;
      longint unsigned term;
      int e;
      acc = 0;
      if (i == 0) return PI_4_Q32;
      for (int k = 0; k < 64; k++) begin
        e = i * (2 * k + 1);
        if (e <= 60) begin
          term = (64'd1 << (60 - e)) / longint'(2 * k + 1);
          if (k & 1) acc = acc - term;
          else acc = acc + term;
        end
      end
      return longint'((acc + (64'd1 << 27)) >> 28);
    endfunction

    // Vectoring rotation: atan2(y, x) in Q32 radians.
    function longint heading_q32(longint y, longint x);
      longint vx, vy, z, base, dx, dy, t;
      base = 0;
      z = 0;
      if (y == 0 && x >= 0) return 0;
      if (x < 0) begin
        if (y >= 0) begin
          vx = y; vy = -x; base = PI_2_Q32;
        end else begin
          vx = -y; vy = x; base = -PI_2_Q32;
        end
      end else begin
        vx = x; vy = y;
      end
      vx = vx * (64'sd1 << OPERAND_SHIFT);
      vy = vy * (64'sd1 << OPERAND_SHIFT);
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        dx = vy >>> i;
        dy = vx >>> i;
        t  = arctan_step(i);
        if (vy > 0) begin
          vx += dx; vy -= dy; z += t;
        end else begin
          vx -= dx; vy += dy; z -= t;
        end
      end
      return base + z;
    endfunction

    // Radians Q32 to degrees with ANGLE_FRAC_BITS fraction bits, half away from zero.
    function longint degrees(longint z);
      longint unsigned mag, d;
      mag = (z < 0) ? longint'(-z) : z;
      d = (mag * 64'd961263669 + (64'd1 << (DEG_SH - 1))) >> DEG_SH;
      return (z < 0) ? -longint'(d) : longint'(d);
    endfunction

    function longint unsigned int_root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function logic [POS_W-1:0] servo_ticks(longint ang);
      longint unsigned p;
      if (ang <= 0) return '0;
      p = (longint'(ang) * longint'(ticks)) >> POS_SH;
      if (p > SERVO_MAX) p = SERVO_MAX;
      return p[POS_W-1:0];
    endfunction

    // Accepted target: predict its servo positions.
    function void note_target(int x, int y);
      longint r2, lim, base, a, sh, el, wr;
      joint_pos_t e;
      r2  = x * x + y * y;
      lim = 4 * seg_len * seg_len;
      if (x == 0 && y == 0) begin
        e.flag = 1'b1;
        base = 0;
        a = 90 << ANGLE_FRAC_BITS;
      end else begin
        base = degrees(heading_q32(y, x));
        if (r2 > lim) begin
          e.flag = 1'b1;
          a = 0;
        end else begin
          e.flag = 1'b0;
          a = degrees(heading_q32(int_root((lim - r2) << 16), int_root(r2 << 16)));
        end
      end
      sh = base + a;
      el = (180 << ANGLE_FRAC_BITS) - 2 * a;
      wr = (270 << ANGLE_FRAC_BITS) - sh - el;
      e.shoulder = servo_ticks(sh);
      e.elbow    = servo_ticks(el);
      e.wrist    = servo_ticks(wr);
      owed.push_back(e);
    endfunction

    function void check_result(logic [39:0] data, logic user);
      joint_pos_t e;
      if (owed.size() == 0) begin
        $error("result transfer with nothing expected: tdata %h", data);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (data[10:0] !== e.shoulder) begin
        $error("shoulder_pos: expected %0d, got %0d", e.shoulder, data[10:0]);
        errors++;
      end
      if (data[21:11] !== e.elbow) begin
        $error("elbow_pos: expected %0d, got %0d", e.elbow, data[21:11]);
        errors++;
      end
      if (data[32:22] !== e.wrist) begin
        $error("wrist_pos: expected %0d, got %0d", e.wrist, data[32:22]);
        errors++;
      end
      if (user !== e.flag) begin
        $error("out_of_reach: expected %0b, got %0b", e.flag, user);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata = '0;  // target_x [8:0], target_y [17:9]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [39:0]          m_axis_tdata;       // shoulder [10:0], elbow [21:11], wrist [32:22]
  logic                 m_axis_tuser;       // out_of_reach
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [TICK_W-1:0]    cfg_data_i = '0;

  joint_scoreboard sb = new();
  int src_idle  = 0;   // percent of cycles the sender holds tvalid low
  int sink_idle = 0;   // percent of cycles the receiver holds tready low
  int hold_left = 0;   // long receiver hold-off, counted down by the receiver
  longint cycles = 0;

  two_link_arm_inverse_kinematics DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watchdog: far above the slowest correct run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: checks each result transfer, then picks tready for the next edge.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle);
      end
    end
  end

  // One target transfer; an optional idle gap first, then hold until accepted.
  task automatic send_target(int x, int y);
    if (src_idle > 0 && $urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, 9'(y), 9'(x)};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_target(x, y);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
  endtask

  // Register writes only with the pipe empty.
  task automatic write_reg(cfg_reg_e idx, int unsigned val);
    drain();
    repeat (2) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[TICK_W-1:0];
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Mostly points in the square around the reachable disc, the rest anywhere in -254 to 254.
  task automatic random_targets(int n);
    int span, x, y;
    for (int i = 0; i < n; i++) begin
      span = 2 * sb.seg_len;
      if (span > 254) span = 254;
      if ($urandom_range(99) < 70 && span > 0) begin
        x = $urandom_range(2 * span) - span;
        y = $urandom_range(2 * span) - span;
      end else begin
        x = $urandom_range(508) - 254;
        y = $urandom_range(508) - 254;
      end
      send_target(x, y);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset registers (L = 10), origin, axes, full reach, corners.
    send_target(0, 0);
    send_target(20, 0);
    send_target(0, 20);
    send_target(-20, 0);
    send_target(0, -20);
    send_target(12, 16);
    send_target(1, 0);
    send_target(-1, 0);
    send_target(0, -1);
    send_target(-7, 4);
    send_target(5, -3);
    send_target(254, 254);
    send_target(-254, -254);
    send_target(-254, 254);
    send_target(254, -1);
    send_target(21, 0);
    // Longest arm, fastest servo scale: saturation.
    write_reg(REG_SEG_LEN, 127);
    write_reg(REG_TICKS, 8191);
    send_target(254, 0);
    send_target(-180, 180);
    send_target(3, 2);
    // Zero segment length: only the origin is not beyond reach.
    write_reg(REG_SEG_LEN, 0);
    write_reg(REG_TICKS, 0);
    send_target(0, 0);
    send_target(1, 1);
    // Shortest arm.
    write_reg(REG_SEG_LEN, 1);
    write_reg(REG_TICKS, 2911);
    send_target(2, 0);
    send_target(1, -1);
    send_target(0, 1);

    // Random, phase 1: sender idles rarely, receiver often; long hold-off midway.
    src_idle = 8;
    sink_idle = 46;
    write_reg(REG_SEG_LEN, 10);
    random_targets(60);
    hold_left = 300;
    random_targets(90);

    // Phase 2: roles swapped; a full drain in the middle.
    src_idle = 46;
    sink_idle = 8;
    write_reg(REG_SEG_LEN, $urandom_range(1, 127));
    write_reg(REG_TICKS, $urandom_range(0, 8191));
    random_targets(75);
    drain();
    write_reg(REG_SEG_LEN, 127);
    write_reg(REG_TICKS, $urandom_range(0, 8191));
    random_targets(75);

    // Phase 3: no idling at all.
    src_idle = 0;
    sink_idle = 0;
    write_reg(REG_SEG_LEN, $urandom_range(0, 8191));
    write_reg(REG_TICKS, 8191);
    random_targets(75);
    write_reg(REG_SEG_LEN, 64);
    write_reg(REG_TICKS, 1000);
    random_targets(75);

    drain();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/tlik_pkg.sv
sv/tlik_sqrt.sv
sv/tlik_cordic.sv
sv/two_link_arm_inverse_kinematics.sv
tb/sv/testbench.sv
